FILE: rtl/ipsv_pkg.sv
`default_nettype none

package ipsv_pkg;

    // Time unit: one PWM period is 2^TIME_LOG2.
    localparam int TIME_LOG2 = 16;
    localparam logic [TIME_LOG2:0] TIME_ONE = (TIME_LOG2+1)'(1) << TIME_LOG2;

    // Field and register widths.
    localparam int VOLT_W     = 16;
    localparam int CMP_W      = 16;
    localparam int K_W        = 16;
    localparam int PER_W      = 16;
    localparam int DUTY_W     = 17;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    // Inverse Park and projection datapath.
    localparam int PROD_W  = 2 * VOLT_W;
    localparam int AB_W    = PROD_W + 1;
    localparam int SQ_FRAC = 16;
    localparam int SQ_W    = SQ_FRAC + 2;
    localparam int SA_W    = AB_W + SQ_FRAC;
    localparam int E_W     = SA_W + 1;
    localparam int PROJ_W  = 35;
    localparam logic signed [SQ_W-1:0] SQRT3_HALF = 18'sd56756;

    // Active time datapath.
    localparam int KP_W    = 52;
    localparam int K_SHIFT = 17;
    localparam int A_W     = KP_W - K_SHIFT + 1;
    localparam int T_SHIFT = 24 - TIME_LOG2;
    localparam int TIME_W  = 26;

    // Proportional scaling divider.
    localparam int SUM_W      = TIME_W + 1;
    localparam int REM_W      = SUM_W + 1;
    localparam int QUO_W      = TIME_LOG2 + 1;
    localparam int DIV_STEPS  = QUO_W;
    localparam int STEPS_PER  = 2;
    localparam int DIV_STAGES = (DIV_STEPS + STEPS_PER - 1) / STEPS_PER;

    // Compare scaling.
    localparam int PRD_W = QUO_W + PER_W;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_K_GAIN       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_LIMIT   = 2'd2;

    localparam logic [K_W-1:0]    K_GAIN_RST       = 16'd9459;
    localparam logic [PER_W-1:0]  PERIOD_COUNT_RST = 16'd4199;
    localparam logic [DUTY_W-1:0] DUTY_LIMIT_RST   = 17'd52429;

    typedef enum logic [2:0] {
        SEC_1 = 3'd1,
        SEC_2 = 3'd2,
        SEC_3 = 3'd3,
        SEC_4 = 3'd4,
        SEC_5 = 3'd5,
        SEC_6 = 3'd6
    } t_sector;

    typedef struct packed {
        t_sector                   sector;
        logic signed [PROJ_W-1:0]  p1;
        logic signed [PROJ_W-1:0]  p2;
        logic signed [PROJ_W-1:0]  p3;
    } t_proj;

    typedef struct packed {
        t_sector           sector;
        logic [TIME_W-1:0] x;
        logic [TIME_W-1:0] y;
    } t_act;

    typedef struct packed {
        t_sector          sector;
        logic             over;
        logic [QUO_W-1:0] x;
        logic [QUO_W-1:0] y;
    } t_fit;

    typedef struct packed {
        logic [CMP_W-1:0] compare_u;
        logic [CMP_W-1:0] compare_v;
        logic [CMP_W-1:0] compare_w;
        t_sector          sector;
        logic             over;
    } t_result;

endpackage

`default_nettype wire

FILE: rtl/ipsv_park.sv
`default_nettype none

module ipsv_park import ipsv_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  logic signed [VOLT_W-1:0] i_volt_d,
    input  logic signed [VOLT_W-1:0] i_volt_q,
    input  logic signed [VOLT_W-1:0] i_sin_angle,
    input  logic signed [VOLT_W-1:0] i_cos_angle,
    output logic                     o_valid,
    output t_proj                    o_proj
);

    localparam int PARK_STAGES = 5;

    // Sign patterns {p1>0, p2>0, p3>0} of the five regular sectors.
    localparam logic [2:0] CODE_S1 = 3'b101;
    localparam logic [2:0] CODE_S2 = 3'b100;
    localparam logic [2:0] CODE_S3 = 3'b110;
    localparam logic [2:0] CODE_S4 = 3'b010;
    localparam logic [2:0] CODE_S5 = 3'b011;

    localparam logic signed [E_W-1:0] E_ROUND = E_W'(1) <<< (SQ_FRAC - 1);

    logic [PARK_STAGES-1:0]   r_vld;
    logic signed [PROD_W-1:0] r_m_dc, r_m_qs, r_m_qc, r_m_ds;
    logic signed [AB_W-1:0]   r_alpha, r_beta, r_beta3, r_beta4;
    logic signed [SA_W-1:0]   r_sa;
    logic signed [E_W-1:0]    r_e2, r_e3;
    t_proj                    r_proj;

    logic signed [E_W-1:0] n_hb, n_e2, n_e3, n_r2, n_r3, n_s2, n_s3;
    logic [2:0]            n_code;
    t_proj                 n_proj;

    always_comb begin
        n_hb = E_W'(r_beta3) <<< (SQ_FRAC - 1);
        n_e2 = -E_W'(r_sa) - n_hb;
        n_e3 = E_W'(r_sa) - n_hb;
    end

    always_comb begin
        n_code = {!r_beta4[AB_W-1] && (r_beta4 != '0),
                  !r_e2[E_W-1] && (r_e2 != '0),
                  !r_e3[E_W-1] && (r_e3 != '0)};
        n_r2 = r_e2 + E_ROUND;
        n_r3 = r_e3 + E_ROUND;
        n_s2 = n_r2 >>> SQ_FRAC;
        n_s3 = n_r3 >>> SQ_FRAC;
        n_proj.p1 = PROJ_W'(r_beta4);
        n_proj.p2 = n_s2[PROJ_W-1:0];
        n_proj.p3 = n_s3[PROJ_W-1:0];
        unique case (n_code)
            CODE_S1: n_proj.sector = SEC_1;
            CODE_S2: n_proj.sector = SEC_2;
            CODE_S3: n_proj.sector = SEC_3;
            CODE_S4: n_proj.sector = SEC_4;
            CODE_S5: n_proj.sector = SEC_5;
            default: n_proj.sector = SEC_6;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[PARK_STAGES-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m_dc  <= i_volt_d * i_cos_angle;
            r_m_qs  <= i_volt_q * i_sin_angle;
            r_m_qc  <= i_volt_q * i_cos_angle;
            r_m_ds  <= i_volt_d * i_sin_angle;
            r_alpha <= AB_W'(r_m_dc) - AB_W'(r_m_qs);
            r_beta  <= AB_W'(r_m_qc) + AB_W'(r_m_ds);
            r_sa    <= SA_W'(r_alpha) * SA_W'(SQRT3_HALF);
            r_beta3 <= r_beta;
            r_e2    <= n_e2;
            r_e3    <= n_e3;
            r_beta4 <= r_beta3;
            r_proj  <= n_proj;
        end
    end

    assign o_valid = r_vld[PARK_STAGES-1];
    assign o_proj  = r_proj;

endmodule

`default_nettype wire

FILE: rtl/ipsv_time.sv
`default_nettype none

module ipsv_time import ipsv_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  t_proj          i_proj,
    input  logic [K_W-1:0] i_k_gain,
    output logic           o_valid,
    output t_act           o_act
);

    localparam int TIME_STAGES = 4;
    localparam logic signed [KP_W-1:0] KP_ROUND = KP_W'(1) <<< (K_SHIFT - 1);
    localparam logic signed [A_W-1:0]  A_ROUND  = A_W'(1) <<< (T_SHIFT - 1);

    logic [TIME_STAGES-1:0]   r_vld;
    t_sector                  r_sec1, r_sec2, r_sec3;
    logic signed [PROJ_W-1:0] r_vx, r_vy;
    logic signed [KP_W-1:0]   r_px, r_py;
    logic signed [A_W-1:0]    r_ax, r_ay;
    t_act                     r_act;

    logic signed [PROJ_W-1:0] n_vx, n_vy;
    logic signed [K_W:0]      n_k;
    logic signed [KP_W-1:0]   n_rx, n_ry, n_sx, n_sy;
    logic signed [A_W-1:0]    n_tx, n_ty, n_ux, n_uy;

    // Each sector picks two of the projections, with sign, as its two active vectors.
    always_comb begin
        unique case (i_proj.sector)
            SEC_1: begin
                n_vx = i_proj.p3;
                n_vy = i_proj.p1;
            end
            SEC_2: begin
                n_vx = -i_proj.p3;
                n_vy = -i_proj.p2;
            end
            SEC_3: begin
                n_vx = i_proj.p1;
                n_vy = i_proj.p2;
            end
            SEC_4: begin
                n_vx = -i_proj.p1;
                n_vy = -i_proj.p3;
            end
            SEC_5: begin
                n_vx = i_proj.p2;
                n_vy = i_proj.p3;
            end
            default: begin
                n_vx = -i_proj.p2;
                n_vy = -i_proj.p1;
            end
        endcase
    end

    always_comb begin
        n_k  = {1'b0, i_k_gain};
        n_rx = r_px + KP_ROUND;
        n_ry = r_py + KP_ROUND;
        n_sx = n_rx >>> K_SHIFT;
        n_sy = n_ry >>> K_SHIFT;
        n_tx = r_ax + A_ROUND;
        n_ty = r_ay + A_ROUND;
        n_ux = n_tx >>> T_SHIFT;
        n_uy = n_ty >>> T_SHIFT;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[TIME_STAGES-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_vx   <= n_vx;
            r_vy   <= n_vy;
            r_sec1 <= i_proj.sector;
            r_px   <= KP_W'(n_k) * KP_W'(r_vx);
            r_py   <= KP_W'(n_k) * KP_W'(r_vy);
            r_sec2 <= r_sec1;
            r_ax   <= n_sx[A_W-1:0];
            r_ay   <= n_sy[A_W-1:0];
            r_sec3 <= r_sec2;
            // A negative active time counts as zero.
            r_act.x      <= n_ux[A_W-1] ? '0 : n_ux[TIME_W-1:0];
            r_act.y      <= n_uy[A_W-1] ? '0 : n_uy[TIME_W-1:0];
            r_act.sector <= r_sec3;
        end
    end

    assign o_valid = r_vld[TIME_STAGES-1];
    assign o_act   = r_act;

endmodule

`default_nettype wire

FILE: rtl/ipsv_div.sv
`default_nettype none

module ipsv_div import ipsv_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  logic i_valid,
    input  t_act i_act,
    output logic o_valid,
    output t_fit o_fit
);

    // One restoring step: {quotient bit, new remainder}. The first step of a
    // division does not shift, since the dividend never exceeds the divisor.
    function automatic logic [REM_W:0] f_step(
        input logic [REM_W-1:0] rem,
        input logic [REM_W-1:0] den,
        input logic             sh
    );
        logic [REM_W-1:0] a;
        logic [REM_W:0]   d;
        a = sh ? {rem[REM_W-2:0], 1'b0} : rem;
        d = {1'b0, a} - {1'b0, den};
        if (!d[REM_W]) begin
            return {1'b1, d[REM_W-1:0]};
        end
        return {1'b0, a};
    endfunction

    logic [REM_W-1:0] r_rem_x [DIV_STAGES+1];
    logic [REM_W-1:0] r_rem_y [DIV_STAGES+1];
    logic [QUO_W-1:0] r_q_x   [DIV_STAGES+1];
    logic [QUO_W-1:0] r_q_y   [DIV_STAGES+1];
    logic [QUO_W-1:0] r_lx    [DIV_STAGES+1];
    logic [QUO_W-1:0] r_ly    [DIV_STAGES+1];
    logic [SUM_W-1:0] r_sum   [DIV_STAGES+1];
    logic             r_over  [DIV_STAGES+1];
    t_sector          r_sec   [DIV_STAGES+1];
    logic             r_vld   [DIV_STAGES+1];

    logic [SUM_W-1:0] n_sum;

    assign n_sum = SUM_W'(i_act.x) + SUM_W'(i_act.y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem_x[0] <= REM_W'(i_act.x);
            r_rem_y[0] <= REM_W'(i_act.y);
            r_q_x[0]   <= '0;
            r_q_y[0]   <= '0;
            r_lx[0]    <= i_act.x[QUO_W-1:0];
            r_ly[0]    <= i_act.y[QUO_W-1:0];
            r_sum[0]   <= n_sum;
            r_over[0]  <= n_sum > SUM_W'(TIME_ONE);
            r_sec[0]   <= i_act.sector;
        end
    end

    for (genvar g = 1; g <= DIV_STAGES; g++) begin : g_stage
        logic [REM_W-1:0] n_rx, n_ry, n_den;
        logic [QUO_W-1:0] n_qx, n_qy;
        logic [REM_W:0]   n_stx, n_sty;

        always_comb begin
            n_den = REM_W'(r_sum[g-1]);
            n_rx  = r_rem_x[g-1];
            n_ry  = r_rem_y[g-1];
            n_qx  = r_q_x[g-1];
            n_qy  = r_q_y[g-1];
            n_stx = '0;
            n_sty = '0;
            for (int j = 0; j < STEPS_PER; j++) begin
                if ((g - 1) * STEPS_PER + j < DIV_STEPS) begin
                    n_stx = f_step(n_rx, n_den, ((g - 1) * STEPS_PER + j) != 0);
                    n_sty = f_step(n_ry, n_den, ((g - 1) * STEPS_PER + j) != 0);
                    n_rx  = n_stx[REM_W-1:0];
                    n_ry  = n_sty[REM_W-1:0];
                    n_qx  = {n_qx[QUO_W-2:0], n_stx[REM_W]};
                    n_qy  = {n_qy[QUO_W-2:0], n_sty[REM_W]};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_en) begin
                r_vld[g] <= r_vld[g-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem_x[g] <= n_rx;
                r_rem_y[g] <= n_ry;
                r_q_x[g]   <= n_qx;
                r_q_y[g]   <= n_qy;
                r_lx[g]    <= r_lx[g-1];
                r_ly[g]    <= r_ly[g-1];
                r_sum[g]   <= r_sum[g-1];
                r_over[g]  <= r_over[g-1];
                r_sec[g]   <= r_sec[g-1];
            end
        end
    end

    // Without overmodulation both times are at most one period and pass as they are.
    assign o_valid     = r_vld[DIV_STAGES];
    assign o_fit.sector = r_sec[DIV_STAGES];
    assign o_fit.over   = r_over[DIV_STAGES];
    assign o_fit.x      = r_over[DIV_STAGES] ? r_q_x[DIV_STAGES] : r_lx[DIV_STAGES];
    assign o_fit.y      = r_over[DIV_STAGES] ? r_q_y[DIV_STAGES] : r_ly[DIV_STAGES];

endmodule

`default_nettype wire

FILE: rtl/ipsv_phase.sv
`default_nettype none

module ipsv_phase import ipsv_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  t_fit              i_fit,
    input  logic [PER_W-1:0]  i_period_count,
    input  logic [DUTY_W-1:0] i_duty_limit,
    output logic              o_valid,
    output t_result           o_result
);

    localparam int PHASE_STAGES = 3;

    logic [PHASE_STAGES-1:0] r_vld;
    logic [QUO_W-1:0]        r_t_u, r_t_v, r_t_w;
    logic [QUO_W-1:0]        r_c_u, r_c_v, r_c_w;
    logic [PRD_W-1:0]        r_p_u, r_p_v, r_p_w;
    t_sector                 r_sec1, r_sec2, r_sec3;
    logic                    r_ovr1, r_ovr2, r_ovr3;

    logic [QUO_W-1:0] n_xy, n_zr, n_z, n_full, n_part;
    logic [QUO_W-1:0] n_tu, n_tv, n_tw;

    // Scaled times never sum past one period, so the zero time is not negative.
    always_comb begin
        n_xy   = i_fit.x + i_fit.y;
        n_zr   = TIME_ONE - n_xy;
        n_z    = n_zr >> 1;
        n_full = n_xy + n_z;
        n_part = i_fit.y + n_z;
        unique case (i_fit.sector)
            SEC_1: begin
                n_tu = n_full;
                n_tv = n_part;
                n_tw = n_z;
            end
            SEC_2: begin
                n_tu = n_part;
                n_tv = n_full;
                n_tw = n_z;
            end
            SEC_3: begin
                n_tu = n_z;
                n_tv = n_full;
                n_tw = n_part;
            end
            SEC_4: begin
                n_tu = n_z;
                n_tv = n_part;
                n_tw = n_full;
            end
            SEC_5: begin
                n_tu = n_part;
                n_tv = n_z;
                n_tw = n_full;
            end
            default: begin
                n_tu = n_full;
                n_tv = n_z;
                n_tw = n_part;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[PHASE_STAGES-2:0], i_valid};
        end
    end

    // With one period at 2^16 the Q1.16 duty limit is directly the time limit.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t_u  <= n_tu;
            r_t_v  <= n_tv;
            r_t_w  <= n_tw;
            r_sec1 <= i_fit.sector;
            r_ovr1 <= i_fit.over;
            r_c_u  <= (r_t_u > i_duty_limit) ? i_duty_limit : r_t_u;
            r_c_v  <= (r_t_v > i_duty_limit) ? i_duty_limit : r_t_v;
            r_c_w  <= (r_t_w > i_duty_limit) ? i_duty_limit : r_t_w;
            r_sec2 <= r_sec1;
            r_ovr2 <= r_ovr1;
            r_p_u  <= PRD_W'(r_c_u) * PRD_W'(i_period_count);
            r_p_v  <= PRD_W'(r_c_v) * PRD_W'(i_period_count);
            r_p_w  <= PRD_W'(r_c_w) * PRD_W'(i_period_count);
            r_sec3 <= r_sec2;
            r_ovr3 <= r_ovr2;
        end
    end

    assign o_valid            = r_vld[PHASE_STAGES-1];
    assign o_result.compare_u = r_p_u[TIME_LOG2+CMP_W-1:TIME_LOG2];
    assign o_result.compare_v = r_p_v[TIME_LOG2+CMP_W-1:TIME_LOG2];
    assign o_result.compare_w = r_p_w[TIME_LOG2+CMP_W-1:TIME_LOG2];
    assign o_result.sector    = r_sec3;
    assign o_result.over      = r_ovr3;

endmodule

`default_nettype wire

FILE: rtl/inverse_park_svpwm.sv
// A transaction passes the Park, active time, divider and phase pipelines
// and then the registered output stage before it reaches the outputs.
// Throughput: one transaction per cycle, fully pipelined, while the skid stage
// is empty; the divider retires two quotient bits per stage over nine stages.
// Reset (synchronous, active low) empties the pipeline and the output skid
// stage and loads the configuration registers with their default values.
`default_nettype none

module inverse_park_svpwm import ipsv_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic signed [VOLT_W-1:0] i_volt_d,
    input  logic signed [VOLT_W-1:0] i_volt_q,
    input  logic signed [VOLT_W-1:0] i_sin_angle,
    input  logic signed [VOLT_W-1:0] i_cos_angle,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [CMP_W-1:0]      o_compare_u,
    output logic [CMP_W-1:0]      o_compare_v,
    output logic [CMP_W-1:0]      o_compare_w,
    output logic [2:0]            o_sector,
    output logic                  o_overmodulated,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [K_W-1:0]    r_k_gain;
    logic [PER_W-1:0]  r_period_count;
    logic [DUTY_W-1:0] r_duty_limit;

    logic    r_out_vld, r_skid_vld;
    t_result r_out, r_skid;

    logic    w_en;
    logic    w_park_vld, w_time_vld, w_div_vld, w_pipe_vld;
    t_proj   w_proj;
    t_act    w_act;
    t_fit    w_fit;
    t_result w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k_gain       <= K_GAIN_RST;
            r_period_count <= PERIOD_COUNT_RST;
            r_duty_limit   <= DUTY_LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_K_GAIN:       r_k_gain       <= i_cfg_data[K_W-1:0];
                CFG_PERIOD_COUNT: r_period_count <= i_cfg_data[PER_W-1:0];
                CFG_DUTY_LIMIT:   r_duty_limit   <= i_cfg_data[DUTY_W-1:0];
                default: ;
            endcase
        end
    end

    // The whole pipeline advances unless the skid stage holds a result.
    assign w_en       = !r_skid_vld;
    assign o_in_ready = w_en;

    ipsv_park u_park (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_en),
        .i_valid     (i_in_valid),
        .i_volt_d    (i_volt_d),
        .i_volt_q    (i_volt_q),
        .i_sin_angle (i_sin_angle),
        .i_cos_angle (i_cos_angle),
        .o_valid     (w_park_vld),
        .o_proj      (w_proj)
    );

    ipsv_time u_time (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (w_park_vld),
        .i_proj   (w_proj),
        .i_k_gain (r_k_gain),
        .o_valid  (w_time_vld),
        .o_act    (w_act)
    );

    ipsv_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_time_vld),
        .i_act   (w_act),
        .o_valid (w_div_vld),
        .o_fit   (w_fit)
    );

    ipsv_phase u_phase (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (w_en),
        .i_valid        (w_div_vld),
        .i_fit          (w_fit),
        .i_period_count (r_period_count),
        .i_duty_limit   (r_duty_limit),
        .o_valid        (w_pipe_vld),
        .o_result       (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (!r_out_vld || i_out_ready) begin
            if (r_skid_vld) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end else begin
                r_out_vld <= w_pipe_vld;
            end
        end else if (w_pipe_vld && w_en) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_vld || i_out_ready) begin
            r_out <= r_skid_vld ? r_skid : w_res;
        end else if (w_pipe_vld && w_en) begin
            r_skid <= w_res;
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_compare_u     = r_out.compare_u;
    assign o_compare_v     = r_out.compare_v;
    assign o_compare_w     = r_out.compare_w;
    assign o_sector        = r_out.sector;
    assign o_overmodulated = r_out.over;

endmodule

`default_nettype wire

FILE: rtl/ipsv_checker.sv
`default_nettype none

module ipsv_checker import ipsv_pkg::*; (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     o_in_ready,
    input logic                     o_out_valid,
    input logic                     i_out_ready,
    input logic [CMP_W-1:0]         o_compare_u,
    input logic [CMP_W-1:0]         o_compare_v,
    input logic [CMP_W-1:0]         o_compare_w,
    input logic [2:0]               o_sector,
    input logic                     o_overmodulated
);

    // Reset leaves no result pending and the input side open.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("result pending or input blocked after reset");

    // A result that is not taken holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid
            && $stable({o_compare_u, o_compare_v, o_compare_w, o_sector, o_overmodulated}))
        else $error("result dropped or changed while stalled");

    // Every delivered result names a real sector.
    a_sector_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_sector >= SEC_1 && o_sector <= SEC_6)
        else $error("sector out of range");

    // The input side only closes because a result was left waiting.
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> $past(o_out_valid && !i_out_ready))
        else $error("input blocked without an output stall");

endmodule

bind inverse_park_svpwm ipsv_checker u_ipsv_checker (.*);

`default_nettype wire
